FILE: rtl/core/i2cbe_pkg.sv
// i2cbe_pkg: shared types and constants of the i2c master bit engine
// holds register codes, command codes, reset values and the structs passed between modules
// no dependencies
package i2cbe_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_START_STOP_DELAY  = 3'd0;
  localparam logic [2:0] REG_WRITE_HALF_PERIOD = 3'd1;
  localparam logic [2:0] REG_READ_HALF_PERIOD  = 3'd2;
  localparam logic [2:0] REG_ACK_SETTLE_DELAY  = 3'd3;
  localparam logic [2:0] REG_ACK_PULSE_DELAY   = 3'd4;
  localparam logic [2:0] REG_ACK_POLL_LIMIT    = 3'd5;

  // register reset values
  localparam logic [7:0] RST_START_STOP_DELAY  = 8'd5;
  localparam logic [7:0] RST_WRITE_HALF_PERIOD = 8'd2;
  localparam logic [7:0] RST_READ_HALF_PERIOD  = 8'd5;
  localparam logic [7:0] RST_ACK_SETTLE_DELAY  = 8'd1;
  localparam logic [7:0] RST_ACK_PULSE_DELAY   = 8'd2;
  localparam logic [7:0] RST_ACK_POLL_LIMIT    = 8'd250;

  // command codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_STOP  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // bits per byte on the bus
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [7:0] start_stop_delay;
    logic [7:0] write_half_period;
    logic [7:0] read_half_period;
    logic [7:0] ack_settle_delay;
    logic [7:0] ack_pulse_delay;
    logic [7:0] ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_is_input;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_timeout;
  } res_t;

endpackage

FILE: rtl/core/i2cbe_cfg_regs.sv
// i2cbe_cfg_regs: timing and poll limit registers of the i2c master bit engine
// written through the configuration channel, depends on i2cbe_pkg
module i2cbe_cfg_regs
  import i2cbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [7:0] wr_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_START_STOP_DELAY:  cfg_nxt.start_stop_delay  = wr_data;
        REG_WRITE_HALF_PERIOD: cfg_nxt.write_half_period = wr_data;
        REG_READ_HALF_PERIOD:  cfg_nxt.read_half_period  = wr_data;
        REG_ACK_SETTLE_DELAY:  cfg_nxt.ack_settle_delay  = wr_data;
        REG_ACK_PULSE_DELAY:   cfg_nxt.ack_pulse_delay   = wr_data;
        REG_ACK_POLL_LIMIT:    cfg_nxt.ack_poll_limit    = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_stop_delay  <= RST_START_STOP_DELAY;
      cfg_r.write_half_period <= RST_WRITE_HALF_PERIOD;
      cfg_r.read_half_period  <= RST_READ_HALF_PERIOD;
      cfg_r.ack_settle_delay  <= RST_ACK_SETTLE_DELAY;
      cfg_r.ack_pulse_delay   <= RST_ACK_PULSE_DELAY;
      cfg_r.ack_poll_limit    <= RST_ACK_POLL_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/i2cbe_seq.sv
// i2cbe_seq: phase sequencer of the i2c master bit engine, one step per accepted tick
// holds phase, counters, shift register and line state; depends on i2cbe_pkg
module i2cbe_seq
  import i2cbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       cmd_valid,
  input  logic [1:0] req_type,
  input  logic [7:0] tx_byte,
  input  logic       ack_after_read,
  input  logic       sda_sample,
  input  cfg_t       cfg,
  output res_t       res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_S1, PH_S2, PH_P1, PH_P2, PH_WLOW, PH_WHIGH, PH_WTAIL,
    PH_ASET, PH_AHOLD, PH_APOLL, PH_AEND, PH_RHIGH, PH_RLOW, PH_KLOW, PH_KHIGH
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       sda_in_r, sda_in_nxt;
  logic       ack_mode_r, ack_mode_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic       nack_r, nack_nxt;
  logic       done;
  logic       wait_done;
  logic [7:0] tick_dec;

  // a wait ends once the count is down to one (zero acts as one)
  assign wait_done = (tick_r <= 8'd1);
  assign tick_dec  = tick_r - 8'd1;

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    poll_nxt     = poll_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    sda_in_nxt   = sda_in_r;
    ack_mode_nxt = ack_mode_r;
    rx_nxt       = rx_r;
    nack_nxt     = nack_r;
    done         = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (cmd_valid) begin
          case (req_type)
            REQ_START: begin
              sda_in_nxt = 1'b0; sda_nxt = 1'b1; scl_nxt = 1'b1;
              phase_nxt = PH_S1; tick_nxt = cfg.start_stop_delay;
            end
            REQ_STOP: begin
              sda_in_nxt = 1'b0; sda_nxt = 1'b0; scl_nxt = 1'b1;
              phase_nxt = PH_P1; tick_nxt = cfg.start_stop_delay;
            end
            REQ_WRITE: begin
              sda_in_nxt = 1'b0; scl_nxt = 1'b0;
              shift_nxt = tx_byte; bit_nxt = 4'd0;
              sda_nxt = tx_byte[7];
              phase_nxt = PH_WLOW; tick_nxt = cfg.write_half_period;
            end
            default: begin
              sda_nxt = 1'b1; sda_in_nxt = 1'b1; scl_nxt = 1'b1;
              shift_nxt = 8'd0; bit_nxt = 4'd0;
              ack_mode_nxt = ack_after_read;
              phase_nxt = PH_RHIGH; tick_nxt = cfg.read_half_period;
            end
          endcase
        end
      end
      PH_S1: begin
        if (wait_done) begin
          sda_nxt = 1'b0; phase_nxt = PH_S2; tick_nxt = cfg.start_stop_delay;
        end else tick_nxt = tick_dec;
      end
      PH_S2: begin
        if (wait_done) begin
          scl_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1;
        end else tick_nxt = tick_dec;
      end
      PH_P1: begin
        if (wait_done) begin
          sda_nxt = 1'b1; phase_nxt = PH_P2; tick_nxt = cfg.start_stop_delay;
        end else tick_nxt = tick_dec;
      end
      PH_P2: begin
        if (wait_done) begin
          phase_nxt = PH_IDLE; done = 1'b1;
        end else tick_nxt = tick_dec;
      end
      PH_WLOW: begin
        if (wait_done) begin
          scl_nxt = 1'b1; phase_nxt = PH_WHIGH; tick_nxt = cfg.write_half_period;
        end else tick_nxt = tick_dec;
      end
      PH_WHIGH: begin
        if (wait_done) begin
          scl_nxt = 1'b0; phase_nxt = PH_WTAIL; tick_nxt = cfg.write_half_period;
        end else tick_nxt = tick_dec;
      end
      PH_WTAIL: begin
        if (wait_done) begin
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_r + 4'd1;
          if (bit_nxt < BITS_PER_BYTE) begin
            sda_nxt = shift_nxt[7];
            phase_nxt = PH_WLOW; tick_nxt = cfg.write_half_period;
          end else begin
            // release sda for the slave ack
            sda_nxt = 1'b1; sda_in_nxt = 1'b1;
            phase_nxt = PH_ASET; tick_nxt = cfg.ack_settle_delay;
          end
        end else tick_nxt = tick_dec;
      end
      PH_ASET: begin
        if (wait_done) begin
          scl_nxt = 1'b1; phase_nxt = PH_AHOLD; tick_nxt = cfg.ack_settle_delay;
        end else tick_nxt = tick_dec;
      end
      PH_AHOLD: begin
        if (wait_done) begin
          poll_nxt = 8'd0; phase_nxt = PH_APOLL;
        end else tick_nxt = tick_dec;
      end
      PH_APOLL: begin
        if (!sda_sample) begin
          nack_nxt = 1'b0; scl_nxt = 1'b0;
          phase_nxt = PH_AEND; tick_nxt = cfg.ack_settle_delay;
        end else if (poll_r >= cfg.ack_poll_limit) begin
          // no ack in time: flag it and run a stop
          nack_nxt = 1'b1;
          sda_in_nxt = 1'b0; sda_nxt = 1'b0; scl_nxt = 1'b1;
          phase_nxt = PH_P1; tick_nxt = cfg.start_stop_delay;
        end else begin
          poll_nxt = poll_r + 8'd1;
        end
      end
      PH_AEND: begin
        if (wait_done) begin
          phase_nxt = PH_IDLE; done = 1'b1;
        end else tick_nxt = tick_dec;
      end
      PH_RHIGH: begin
        if (wait_done) begin
          shift_nxt = {shift_r[6:0], sda_sample};
          scl_nxt = 1'b0; phase_nxt = PH_RLOW; tick_nxt = cfg.read_half_period;
        end else tick_nxt = tick_dec;
      end
      PH_RLOW: begin
        if (wait_done) begin
          bit_nxt = bit_r + 4'd1;
          if (bit_nxt < BITS_PER_BYTE) begin
            scl_nxt = 1'b1; phase_nxt = PH_RHIGH; tick_nxt = cfg.read_half_period;
          end else begin
            scl_nxt = 1'b0; sda_in_nxt = 1'b0;
            sda_nxt = ~ack_mode_r;
            phase_nxt = PH_KLOW; tick_nxt = cfg.ack_pulse_delay;
          end
        end else tick_nxt = tick_dec;
      end
      PH_KLOW: begin
        if (wait_done) begin
          scl_nxt = 1'b1; phase_nxt = PH_KHIGH; tick_nxt = cfg.ack_pulse_delay;
        end else tick_nxt = tick_dec;
      end
      PH_KHIGH: begin
        if (wait_done) begin
          scl_nxt = 1'b0; rx_nxt = shift_r;
          phase_nxt = PH_IDLE; done = 1'b1;
        end else tick_nxt = tick_dec;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_r     <= 8'd0;
      bit_r      <= 4'd0;
      shift_r    <= 8'd0;
      poll_r     <= 8'd0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      sda_in_r   <= 1'b0;
      ack_mode_r <= 1'b0;
      rx_r       <= 8'd0;
      nack_r     <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      bit_r      <= bit_nxt;
      shift_r    <= shift_nxt;
      poll_r     <= poll_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      sda_in_r   <= sda_in_nxt;
      ack_mode_r <= ack_mode_nxt;
      rx_r       <= rx_nxt;
      nack_r     <= nack_nxt;
    end
  end

  always_comb begin
    res.scl_level    = scl_nxt;
    res.sda_level    = sda_nxt;
    res.sda_is_input = sda_in_nxt;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.done_res     = done;
    res.rx_byte      = rx_nxt;
    res.nack_timeout = nack_nxt;
  end

endmodule

FILE: rtl/core/i2cbe_out_reg.sv
// i2cbe_out_reg: result register of the i2c master bit engine, holds one word until taken
// depends on i2cbe_pkg
module i2cbe_out_reg
  import i2cbe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_in,
  input  logic take,
  output logic full,
  output res_t res_out
);

  logic full_r, full_nxt;
  res_t res_r;

  always_comb begin
    full_nxt = full_r;
    if (load)      full_nxt = 1'b1;
    else if (take) full_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign full    = full_r;
  assign res_out = res_r;

endmodule

FILE: rtl/core/i2c_master_bit_engine_core.sv
// i2c_master_bit_engine_core: top level of the i2c master bit engine
// ties the configuration registers, the phase sequencer and the result register
// depends on i2cbe_pkg, i2cbe_cfg_regs, i2cbe_seq, i2cbe_out_reg
//
// Each input word is one tick of the bit timing base: it carries the sampled sda level
// and, while the engine is idle, may start a command (start, stop, write byte, read
// byte with ack or nack). Every accepted word yields exactly one result word with the
// scl level, the sda value and direction, busy and done flags, the last received byte
// and the nack timeout flag as they stand after that tick. A word is taken every clock:
// the sequencer steps on the accepting edge and its result lands in a one-word output
// register, so in_tready drops only while that register is full and out_tready is low.
// The result is valid in the cycle after its word is accepted. Commands offered
// while busy are ignored. Timing registers are written over the cfg channel, which is
// always ready; write them only while no result is pending. Indexes 6 and 7 are ignored.
module i2c_master_bit_engine_core
  import i2cbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] cmd_valid, [8:1] tx_byte, [9] ack_after_read, [10] sda_sample, [15:11] zero
  input  logic [15:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]  in_tuser,
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_is_input, [3] busy_res, [4] done_res,
  // [12:5] rx_byte, [13] nack_timeout, [15:14] zero
  output logic [15:0] out_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t cfg;
  res_t seq_res;
  res_t out_res;
  logic out_full;
  logic in_accept;
  logic out_take;

  // the result register frees up in the same cycle it is read
  assign out_take  = out_full & out_tready;
  assign in_tready = ~out_full | out_tready;
  assign in_accept = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  i2cbe_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  i2cbe_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (in_accept),
    .cmd_valid      (in_tdata[0]),
    .req_type       (in_tuser),
    .tx_byte        (in_tdata[8:1]),
    .ack_after_read (in_tdata[9]),
    .sda_sample     (in_tdata[10]),
    .cfg            (cfg),
    .res            (seq_res)
  );

  i2cbe_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_accept),
    .res_in  (seq_res),
    .take    (out_take),
    .full    (out_full),
    .res_out (out_res)
  );

  assign out_tvalid = out_full;

  // pack the result word, lowest field first
  assign out_tdata = {2'b00,
                      out_res.nack_timeout,
                      out_res.rx_byte,
                      out_res.done_res,
                      out_res.busy_res,
                      out_res.sda_is_input,
                      out_res.sda_level,
                      out_res.scl_level};

endmodule

FILE: dv/i2c_master_bit_engine_core_tb.sv
// i2c_master_bit_engine_core_tb: self-checking bench for the i2c master bit engine
// predicts scl, sda, direction and status for every tick word and checks each result word
// depends on i2cbe_pkg and i2c_master_bit_engine_core
`timescale 1ns / 1ps

module i2c_master_bit_engine_core_tb;
  import i2cbe_pkg::*;

  // indexes past the last register, writes there must be dropped
  localparam logic [2:0] IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;

  // ack poll wait that outlasts any poll limit
  localparam int NEVER_ACK = 1000;
  localparam int RANDOM_TICKS = 400;
  localparam int MIN_FINISHED = 12;
  localparam int MAX_REPORTS = 30;

  // sequencer phases of the bit engine
  typedef enum logic [4:0] {
    ST_IDLE, ST_START_SETUP, ST_START_HOLD, ST_STOP_SETUP, ST_STOP_HOLD,
    ST_WR_LOW, ST_WR_HIGH, ST_WR_TAIL, ST_ACK_SETUP, ST_ACK_HOLD, ST_ACK_POLL,
    ST_ACK_END, ST_RD_HIGH, ST_RD_LOW, ST_MACK_LOW, ST_MACK_HIGH
  } seq_e;

  // how sda is driven on ticks outside the ack poll
  typedef enum int {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_mode_e;

  // line state predictor plus the queue of expected result words
  class line_board;
    cfg_t       regs;
    seq_e       st;
    logic [7:0] ticks, shreg, polls, rx;
    logic [3:0] bitno;
    logic       scl, sda, sda_rel, ack_mode, nack;
    res_t       expected_lines[$];
    int         n_err, n_checked, n_done, n_timeouts, n_acks;
    int         n_cmds[4];

    function new();
      regs.start_stop_delay  = RST_START_STOP_DELAY;
      regs.write_half_period = RST_WRITE_HALF_PERIOD;
      regs.read_half_period  = RST_READ_HALF_PERIOD;
      regs.ack_settle_delay  = RST_ACK_SETTLE_DELAY;
      regs.ack_pulse_delay   = RST_ACK_PULSE_DELAY;
      regs.ack_poll_limit    = RST_ACK_POLL_LIMIT;
      st = ST_IDLE;
      ticks = '0; shreg = '0; polls = '0; rx = '0; bitno = '0;
      scl = 1'b1; sda = 1'b1; sda_rel = 1'b0; ack_mode = 1'b0; nack = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        REG_START_STOP_DELAY:  regs.start_stop_delay  = val;
        REG_WRITE_HALF_PERIOD: regs.write_half_period = val;
        REG_READ_HALF_PERIOD:  regs.read_half_period  = val;
        REG_ACK_SETTLE_DELAY:  regs.ack_settle_delay  = val;
        REG_ACK_PULSE_DELAY:   regs.ack_pulse_delay   = val;
        REG_ACK_POLL_LIMIT:    regs.ack_poll_limit    = val;
        default: ;
      endcase
    endfunction

    // a wait of d ticks, zero counts as one
    function bit expired();
      if (ticks > 8'd1) begin
        ticks--;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void enter(seq_e s, logic [7:0] d);
      st = s;
      ticks = d;
    endfunction

    function void to_stop();
      sda_rel = 1'b0;
      sda = 1'b0;
      scl = 1'b1;
      enter(ST_STOP_SETUP, regs.start_stop_delay);
    endfunction

    // one accepted tick word: step the sequencer and queue the line state after it
    function void take_tick(bit cv, logic [1:0] rq, logic [7:0] tx, bit ak, bit sd);
      res_t r;
      bit   fin;
      fin = 1'b0;
      case (st)
        ST_IDLE: if (cv) begin
          n_cmds[rq]++;
          case (rq)
            REQ_START: begin
              sda_rel = 1'b0; sda = 1'b1; scl = 1'b1;
              enter(ST_START_SETUP, regs.start_stop_delay);
            end
            REQ_STOP: to_stop();
            REQ_WRITE: begin
              sda_rel = 1'b0; scl = 1'b0;
              shreg = tx; bitno = '0;
              sda = shreg[7];
              enter(ST_WR_LOW, regs.write_half_period);
            end
            default: begin
              sda = 1'b1; sda_rel = 1'b1; scl = 1'b1;
              shreg = '0; bitno = '0;
              ack_mode = ak;
              enter(ST_RD_HIGH, regs.read_half_period);
            end
          endcase
        end
        ST_START_SETUP: if (expired()) begin
          sda = 1'b0;
          enter(ST_START_HOLD, regs.start_stop_delay);
        end
        ST_START_HOLD: if (expired()) begin
          scl = 1'b0; st = ST_IDLE; fin = 1'b1;
        end
        ST_STOP_SETUP: if (expired()) begin
          sda = 1'b1;
          enter(ST_STOP_HOLD, regs.start_stop_delay);
        end
        ST_STOP_HOLD: if (expired()) begin
          st = ST_IDLE; fin = 1'b1;
        end
        ST_WR_LOW: if (expired()) begin
          scl = 1'b1;
          enter(ST_WR_HIGH, regs.write_half_period);
        end
        ST_WR_HIGH: if (expired()) begin
          scl = 1'b0;
          enter(ST_WR_TAIL, regs.write_half_period);
        end
        ST_WR_TAIL: if (expired()) begin
          shreg = shreg << 1;
          bitno = bitno + 4'd1;
          if (bitno < BITS_PER_BYTE) begin
            sda = shreg[7];
            enter(ST_WR_LOW, regs.write_half_period);
          end else begin
            sda = 1'b1; sda_rel = 1'b1;
            enter(ST_ACK_SETUP, regs.ack_settle_delay);
          end
        end
        ST_ACK_SETUP: if (expired()) begin
          scl = 1'b1;
          enter(ST_ACK_HOLD, regs.ack_settle_delay);
        end
        ST_ACK_HOLD: if (expired()) begin
          polls = '0; st = ST_ACK_POLL;
        end
        ST_ACK_POLL: begin
          if (!sd) begin
            nack = 1'b0; scl = 1'b0; n_acks++;
            enter(ST_ACK_END, regs.ack_settle_delay);
          end else if (polls >= regs.ack_poll_limit) begin
            nack = 1'b1; n_timeouts++;
            to_stop();
          end else begin
            polls++;
          end
        end
        ST_ACK_END: if (expired()) begin
          st = ST_IDLE; fin = 1'b1;
        end
        ST_RD_HIGH: if (expired()) begin
          shreg = {shreg[6:0], sd};
          scl = 1'b0;
          enter(ST_RD_LOW, regs.read_half_period);
        end
        ST_RD_LOW: if (expired()) begin
          bitno = bitno + 4'd1;
          if (bitno < BITS_PER_BYTE) begin
            scl = 1'b1;
            enter(ST_RD_HIGH, regs.read_half_period);
          end else begin
            scl = 1'b0; sda_rel = 1'b0;
            sda = ack_mode ? 1'b0 : 1'b1;
            enter(ST_MACK_LOW, regs.ack_pulse_delay);
          end
        end
        ST_MACK_LOW: if (expired()) begin
          scl = 1'b1;
          enter(ST_MACK_HIGH, regs.ack_pulse_delay);
        end
        ST_MACK_HIGH: if (expired()) begin
          scl = 1'b0; rx = shreg; st = ST_IDLE; fin = 1'b1;
        end
        default: st = ST_IDLE;
      endcase
      if (fin) n_done++;
      r.scl_level    = scl;
      r.sda_level    = sda;
      r.sda_is_input = sda_rel;
      r.busy_res     = (st != ST_IDLE);
      r.done_res     = fin;
      r.rx_byte      = rx;
      r.nack_timeout = nack;
      expected_lines.push_back(r);
    endfunction

    function void cmp(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        n_err++;
        if (n_err <= MAX_REPORTS)
          $error("%s: expected %0h, got %0h (word %0d)", name, exp_v, act_v, n_checked);
      end
    endfunction

    // one accepted result word against the oldest expectation
    function void check_word(logic [15:0] w);
      res_t e;
      if (expected_lines.size() == 0) begin
        n_err++;
        $error("result word %h with nothing expected", w);
        return;
      end
      e = expected_lines.pop_front();
      n_checked++;
      cmp("scl_level",    8'(e.scl_level),    8'(w[0]));
      cmp("sda_level",    8'(e.sda_level),    8'(w[1]));
      cmp("sda_is_input", 8'(e.sda_is_input), 8'(w[2]));
      cmp("busy_res",     8'(e.busy_res),     8'(w[3]));
      cmp("done_res",     8'(e.done_res),     8'(w[4]));
      cmp("rx_byte",      e.rx_byte,          w[12:5]);
      cmp("nack_timeout", 8'(e.nack_timeout), 8'(w[13]));
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [7:0]  cfg_data   = '0;

  line_board sb;

  // sender burst bookkeeping and run statistics
  int burst_left = 0;
  int n_ticks = 0;
  int n_settings = 0;

  // receiver stall pattern: a 16-bit ready mask walked round, swapped every so often
  logic [15:0] stall_mask = 16'hffff;
  int stall_pos = 0;
  int stall_left = 0;

  i2c_master_bit_engine_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check each accepted word, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0, 1: stall_mask = 16'hffff;
        2: stall_mask = 16'($urandom | $urandom);
        default: stall_mask = 16'($urandom & $urandom) | 16'h0101;
      endcase
      stall_left = $urandom_range(16, 200);
    end
    stall_left--;
    stall_pos = (stall_pos + 1) % 16;
    out_tready <= stall_mask[stall_pos];
  end

  // offer one tick word, sometimes after a random gap, and wait for it to be taken
  task automatic put_tick(bit cv, logic [1:0] rq, logic [7:0] tx, bit ak, bit sd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, sd, ak, tx, cv};
    in_tuser  <= rq;
    do @(posedge clk); while (!in_tready);
    sb.take_tick(cv, rq, tx, ak, sd);
    n_ticks++;
  endtask

  task automatic idle_ticks(int n);
    repeat (n)
      put_tick(1'b0, 2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // issue a command and tick it to completion; the slave pulls sda low after
  // ack_wait high poll samples, and stray commands hit the busy engine now and then
  task automatic run_cmd(logic [1:0] rq, logic [7:0] tx, bit ak, int ack_wait,
                         sda_mode_e mode);
    int polled;
    bit sd;
    polled = 0;
    put_tick(1'b1, rq, tx, ak, 1'($urandom));
    while (sb.st != ST_IDLE) begin
      if (sb.st == ST_ACK_POLL) begin
        sd = (polled >= ack_wait) ? 1'b0 : 1'b1;
        polled++;
      end else begin
        case (mode)
          SDA_HIGH: sd = 1'b1;
          SDA_LOW:  sd = 1'b0;
          default:  sd = 1'($urandom);
        endcase
      end
      if ($urandom_range(0, 5) == 0)
        put_tick(1'b1, 2'($urandom), 8'($urandom), 1'($urandom), sd);
      else
        put_tick(1'b0, 2'($urandom), 8'($urandom), 1'($urandom), sd);
    end
  endtask

  // pause the sender until the engine is idle and every result word is back
  task automatic settle_idle();
    while (sb.st != ST_IDLE) idle_ticks(1);
    in_tvalid <= 1'b0;
    while (sb.expected_lines.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_one(logic [2:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // program all six timing registers while idle, optionally poking the spare indexes
  task automatic apply_cfg(cfg_t c, bit spare);
    settle_idle();
    write_one(REG_START_STOP_DELAY,  c.start_stop_delay);
    write_one(REG_WRITE_HALF_PERIOD, c.write_half_period);
    write_one(REG_READ_HALF_PERIOD,  c.read_half_period);
    write_one(REG_ACK_SETTLE_DELAY,  c.ack_settle_delay);
    write_one(REG_ACK_PULSE_DELAY,   c.ack_pulse_delay);
    write_one(REG_ACK_POLL_LIMIT,    c.ack_poll_limit);
    if (spare) begin
      write_one(IDX_SPARE_LO, 8'($urandom));
      write_one(IDX_SPARE_HI, 8'($urandom));
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic cfg_t flat_cfg(logic [7:0] v);
    cfg_t c;
    c = {6{v}};
    return c;
  endfunction

  // mostly short delays so many commands fit, with zero now and then
  function automatic logic [7:0] pick_delay();
    return ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
  endfunction

  // ack right away, after a few polls, exactly at the limit, or never
  function automatic int pick_ack_wait();
    int lim;
    lim = sb.regs.ack_poll_limit;
    case ($urandom_range(0, 7))
      0: return NEVER_ACK;
      1: return lim;
      default: return $urandom_range(0, (lim < 3) ? lim : 3);
    endcase
  endfunction

  // mostly whole bus transfers: start, address, a few data bytes, stop
  task automatic random_transfer();
    int k;
    bit rd_last;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: begin
        run_cmd(REQ_START, 8'($urandom), 1'($urandom), 0, SDA_RANDOM);
        run_cmd(REQ_WRITE, 8'($urandom), 1'($urandom), pick_ack_wait(), SDA_RANDOM);
        // a timed-out address already ended in a stop
        if (sb.nack) return;
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 3) == 0) idle_ticks($urandom_range(1, 3));
          if ($urandom_range(0, 1) == 0) begin
            run_cmd(REQ_WRITE, 8'($urandom), 1'($urandom), pick_ack_wait(), SDA_RANDOM);
            if (sb.nack) return;
          end else begin
            // last byte of a read is usually nacked
            rd_last = (i == k - 1) && ($urandom_range(0, 3) != 0);
            run_cmd(REQ_READ, 8'($urandom), rd_last ? 1'b0 : 1'($urandom_range(0, 3) != 0),
                    0, SDA_RANDOM);
          end
        end
        run_cmd(REQ_STOP, 8'($urandom), 1'($urandom), 0, SDA_RANDOM);
      end
      7: run_cmd(2'($urandom), 8'($urandom), 1'($urandom), pick_ack_wait(), SDA_RANDOM);
      8: idle_ticks($urandom_range(1, 6));
      default: run_cmd(REQ_READ, 8'($urandom), 1'($urandom), 0, SDA_RANDOM);
    endcase
  endtask

  task automatic random_setting();
    cfg_t c;
    c.start_stop_delay  = pick_delay();
    c.write_half_period = pick_delay();
    c.read_half_period  = pick_delay();
    c.ack_settle_delay  = pick_delay();
    c.ack_pulse_delay   = pick_delay();
    case ($urandom_range(0, 7))
      0: c.ack_poll_limit = 8'd0;
      1: c.ack_poll_limit = 8'd250;
      default: c.ack_poll_limit = 8'($urandom_range(1, 10));
    endcase
    apply_cfg(c, $urandom_range(0, 3) == 0);
    repeat ($urandom_range(2, 4)) random_transfer();
  endtask

  // run ceiling, far above the slowest legal run
  initial begin
    #4_000_000;
    $display("i2c_master_bit_engine_core_tb: errors");
    $finish;
  end

  initial begin
    int t0;
    int d0;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing: stop from idle, byte extremes, timeout
    run_cmd(REQ_STOP,  8'h00, 1'b0, 0, SDA_RANDOM);
    run_cmd(REQ_START, 8'h00, 1'b0, 0, SDA_RANDOM);
    run_cmd(REQ_WRITE, 8'hff, 1'b1, 0, SDA_RANDOM);
    run_cmd(REQ_READ,  8'h00, 1'b1, 0, SDA_HIGH);
    run_cmd(REQ_READ,  8'hff, 1'b0, 0, SDA_LOW);
    run_cmd(REQ_WRITE, 8'ha5, 1'b1, NEVER_ACK, SDA_RANDOM);
    // a later ack clears the timeout flag
    run_cmd(REQ_START, 8'h00, 1'b0, 0, SDA_RANDOM);
    run_cmd(REQ_WRITE, 8'h5a, 1'b0, 3, SDA_RANDOM);
    run_cmd(REQ_STOP,  8'h00, 1'b0, 0, SDA_RANDOM);

    // all delays zero act as one, zero poll limit times out on the first high sample
    apply_cfg(flat_cfg(8'd0), 1'b1);
    run_cmd(REQ_START, 8'h00, 1'b0, 0, SDA_RANDOM);
    run_cmd(REQ_WRITE, 8'h80, 1'b0, 0, SDA_RANDOM);
    run_cmd(REQ_WRITE, 8'h01, 1'b1, NEVER_ACK, SDA_RANDOM);
    run_cmd(REQ_READ,  8'h00, 1'b1, 0, SDA_RANDOM);
    run_cmd(REQ_READ,  8'h00, 1'b0, 0, SDA_RANDOM);
    run_cmd(REQ_STOP,  8'h00, 1'b0, 0, SDA_RANDOM);

    // unit timing with a poll limit of one: ack just in time, then one poll too late
    apply_cfg(flat_cfg(8'd1), 1'b0);
    run_cmd(REQ_START, 8'h00, 1'b0, 0, SDA_RANDOM);
    run_cmd(REQ_WRITE, 8'h7e, 1'b0, 1, SDA_RANDOM);
    run_cmd(REQ_WRITE, 8'h81, 1'b0, 2, SDA_RANDOM);
    run_cmd(REQ_READ,  8'h00, 1'b0, 0, SDA_RANDOM);
    run_cmd(REQ_STOP,  8'h00, 1'b0, 0, SDA_RANDOM);

    // random settings, each followed by a batch of transfers
    t0 = n_ticks;
    d0 = sb.n_done;
    while ((n_ticks - t0) < RANDOM_TICKS || (sb.n_done - d0) < MIN_FINISHED)
      random_setting();

    settle_idle();
    repeat (4) @(posedge clk);
    if (sb.expected_lines.size() != 0) begin
      sb.n_err++;
      $error("%0d result words never arrived", sb.expected_lines.size());
    end

    $display("run: %0d tick words over %0d timing settings, %0d commands finished",
             n_ticks, n_settings, sb.n_done);
    $display("commands start %0d stop %0d write %0d read %0d, acks %0d, ack timeouts %0d",
             sb.n_cmds[REQ_START], sb.n_cmds[REQ_STOP], sb.n_cmds[REQ_WRITE],
             sb.n_cmds[REQ_READ], sb.n_acks, sb.n_timeouts);
    if (sb.n_err == 0) begin
      $display("i2c_master_bit_engine_core_tb: clean");
    end else begin
      $display("i2c_master_bit_engine_core_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/i2cbe_pkg.sv
rtl/core/i2cbe_cfg_regs.sv
rtl/core/i2cbe_seq.sv
rtl/core/i2cbe_out_reg.sv
rtl/core/i2c_master_bit_engine_core.sv
dv/i2c_master_bit_engine_core_tb.sv
